[design/srep_pkg.sv]
// Shared constants for the short-rate Euler path stepper.
package srep_pkg;

    // Default sizes
    localparam int DEF_FRAC_BITS        = 24;
    localparam int DEF_SAMPLE_WIDTH     = 16;
    localparam int DEF_STEP_COUNT_WIDTH = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MODEL_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEAN_REVERSION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_RUN_MEAN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_RATE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLATILITY     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SQRT_STEP_TIME = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_PATH = 3'd7;

    localparam logic [15:0] STEPS_RESET = 16'd256;

    // Exponential evaluation, Q30
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam logic [31:0] LN2_Q30   = 32'd744261118;
    localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
    localparam int          EXP_TERMS = 12;
    localparam int          TERM_W    = 31;

    // Shared multiplier: wide operand times 32-bit operand in two 16-bit halves
    localparam int MUL_AW = 56;
    localparam int MUL_BW = 32;
    localparam int MUL_HW = 16;

endpackage

[design/short_rate_euler_path.sv]
// Short-rate path stepper: Euler-Maruyama step, rate integral and discount factor.
// A CIR step with positive rate adds the square root to the Vasicek step sequence
//   (shared multiplier: two 16-bit half products and a post step per product, square root one result bit a cycle).
// Last step of a path adds the exponential, up to 25 products, the series divisions
//   done as reciprocal products. One transaction at a time; in_stall is high while busy.
// Reset (rst_n, async, active low) clears control state, path state and configuration
//   registers to their reset values; datapath and output data registers are not reset; no clearing pass.
module short_rate_euler_path
    import srep_pkg::*;
#(
    parameter int FRAC_BITS        = DEF_FRAC_BITS,
    parameter int SAMPLE_WIDTH     = DEF_SAMPLE_WIDTH,
    parameter int STEP_COUNT_WIDTH = DEF_STEP_COUNT_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] normal_sample,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             new_rate,
    output logic [15:0]                    step_index,
    output logic                           path_end,
    output logic [31:0]                    discount_factor,
    // configuration
    input  logic                           cfg_we,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data
);

    localparam int F     = FRAC_BITS;
    localparam int SF    = SAMPLE_WIDTH - 4;
    localparam int AW    = MUL_AW;
    localparam int PW    = MUL_AW + MUL_HW;
    localparam int CW    = MUL_AW + MUL_BW;
    localparam int YW    = AW + 1;
    localparam int SQ    = (32 + F) / 2;          // root bits of (rate << F)
    localparam int SQV   = 2 * SQ;
    localparam int ITW   = $clog2(SQ + 1);
    localparam int SCW   = STEP_COUNT_WIDTH;

    // series division: q = (x * ceil(2^RECIP_SH / i)) >> RECIP_SH, exact for x < 2^30
    localparam int RECIP_SH = 34;
    localparam int RECIP_W  = 36;

    localparam logic signed [YW-1:0] K_LIMIT = YW'(32 - F);
    localparam logic signed [YW:0]   S_BASE  = (YW + 1)'(30 - F);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_POST, ST_SQRT, ST_EXPFIN, ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_INTG, OP_T1, OP_DRIFT, OP_VG, OP_T2, OP_DIFF, OP_Y, OP_T, OP_TERM, OP_DIV
    } op_t;

    // configuration registers
    logic                  mode_reg;
    logic [30:0]           a_reg;
    logic signed [31:0]    b_reg;
    logic signed [31:0]    r0_reg;
    logic [30:0]           vol_reg;
    logic [24:0]           dt_reg;
    logic [24:0]           sqdt_reg;
    logic [15:0]           steps_reg;

    // sequencer and path state
    state_t                state_reg;
    op_t                   op_reg;
    logic                  phase_reg;
    logic [CW-1:0]         acc_reg;
    logic signed [SAMPLE_WIDTH-1:0] z_reg;
    logic signed [31:0]    rate_reg;
    logic signed [31:0]    cur_rate_reg;
    logic [SCW-1:0]        cnt_reg;
    logic signed [47:0]    integ_reg;
    logic [AW-1:0]         t1_reg;
    logic signed [AW:0]    drift_reg;
    logic [AW-1:0]         vg_reg;
    logic [AW-1:0]         t2_reg;
    logic [SQV-1:0]        sq_val_reg;
    logic [SQ+1:0]         sq_rem_reg;
    logic [SQ-1:0]         sq_root_reg;
    logic [ITW-1:0]        it_reg;
    logic signed [YW-1:0]  k_reg;
    logic [F-1:0]          f_reg;
    logic [TERM_W-1:0]     t_reg;
    logic [TERM_W-1:0]     term_reg;
    logic [31:0]           sum_reg;
    logic [3:0]            div_i_reg;
    logic [TERM_W-1:0]     div_x_reg;
    logic signed [31:0]    nr_reg;
    logic [SCW-1:0]        idx_reg;
    logic                  end_reg;
    logic [31:0]           disc_reg;

    // output register
    logic                  out_valid_reg;
    logic signed [31:0]    out_rate_reg;
    logic [15:0]           out_idx_reg;
    logic                  out_end_reg;
    logic [31:0]           out_disc_reg;

    // ---------------- combinational helpers ----------------
    logic [31:0]           rate_mag;
    logic signed [32:0]    d_val;
    logic [32:0]           d_mag;
    logic [47:0]           integ_mag;
    logic [SAMPLE_WIDTH-1:0] z_mag;

    assign rate_mag  = rate_reg[31] ? (~rate_reg + 32'd1) : rate_reg;
    assign d_val     = {b_reg[31], b_reg} - {rate_reg[31], rate_reg};
    assign d_mag     = d_val[32] ? (~d_val + 33'd1) : d_val;
    assign integ_mag = integ_reg[47] ? (~integ_reg + 48'd1) : integ_reg;
    assign z_mag     = z_reg[SAMPLE_WIDTH-1] ? (~z_reg + SAMPLE_WIDTH'(1)) : z_reg;

    // reciprocal of the series index, ceil(2^34 / i)
    logic [RECIP_W-1:0]    recip;

    always_comb
    begin
        unique case (div_i_reg)
            4'd2:    recip = 36'd8589934592;
            4'd3:    recip = 36'd5726623062;
            4'd4:    recip = 36'd4294967296;
            4'd5:    recip = 36'd3435973837;
            4'd6:    recip = 36'd2863311531;
            4'd7:    recip = 36'd2454267027;
            4'd8:    recip = 36'd2147483648;
            4'd9:    recip = 36'd1908874354;
            4'd10:   recip = 36'd1717986919;
            4'd11:   recip = 36'd1561806290;
            4'd12:   recip = 36'd1431655766;
            default: recip = '0;
        endcase
    end

    // shared multiplier: operand select, half product, accumulate
    logic [AW-1:0]         mul_a;
    logic [MUL_BW-1:0]     mul_b;
    logic [MUL_HW-1:0]     b_half;
    logic [PW-1:0]         prod;
    logic [CW-1:0]         acc_next;
    logic [CW-1:0]         res_full;
    logic [AW-1:0]         res;

    always_comb
    begin
        unique case (op_reg)
            OP_INTG:  begin mul_a = AW'(rate_mag);  mul_b = MUL_BW'(dt_reg);      end
            OP_T1:    begin mul_a = AW'(d_mag);     mul_b = MUL_BW'(a_reg);       end
            OP_DRIFT: begin mul_a = t1_reg;         mul_b = MUL_BW'(dt_reg);      end
            OP_VG:    begin mul_a = AW'(vol_reg);   mul_b = MUL_BW'(sq_root_reg); end
            OP_T2:    begin mul_a = vg_reg;         mul_b = MUL_BW'(z_mag);       end
            OP_DIFF:  begin mul_a = t2_reg;         mul_b = MUL_BW'(sqdt_reg);    end
            OP_Y:     begin mul_a = AW'(integ_mag); mul_b = LOG2E_Q30;            end
            OP_T:     begin mul_a = AW'(f_reg) << (30 - F); mul_b = LN2_Q30;      end
            OP_TERM:  begin mul_a = AW'(term_reg);  mul_b = MUL_BW'(t_reg);       end
            OP_DIV:   begin mul_a = AW'(recip);     mul_b = MUL_BW'(div_x_reg);   end
            default:  begin mul_a = '0;             mul_b = '0;                   end
        endcase
    end

    assign b_half   = phase_reg ? mul_b[MUL_BW-1:MUL_HW] : mul_b[MUL_HW-1:0];
    assign prod     = PW'(mul_a) * PW'(b_half);
    assign acc_next = phase_reg ? (acc_reg + {prod, {MUL_HW{1'b0}}}) : CW'(prod);

    always_comb
    begin
        unique case (op_reg)
            OP_T2:                   res_full = acc_reg >> SF;
            OP_Y, OP_T, OP_TERM:     res_full = acc_reg >> 30;
            OP_DIV:                  res_full = acc_reg >> RECIP_SH;
            default:                 res_full = acc_reg >> F;
        endcase
    end
    assign res = res_full[AW-1:0];

    // post-processing of each product
    logic signed [57:0]    integ_sum;
    logic signed [57:0]    intg_term;
    logic signed [AW:0]    res_pos;
    logic signed [AW:0]    res_neg;
    logic signed [59:0]    nr_sum;
    logic [SCW-1:0]        idx_val;
    logic                  end_val;
    logic signed [YW-1:0]  y_val;
    logic signed [YW-1:0]  k_val;

    assign res_pos   = $signed({1'b0, res});
    assign res_neg   = -res_pos;
    assign intg_term = rate_reg[31] ? 58'(res_neg) : 58'(res_pos);
    assign integ_sum = 58'(integ_reg) + intg_term;
    assign nr_sum    = 60'(rate_reg) + 60'(drift_reg)
                     + (z_reg[SAMPLE_WIDTH-1] ? 60'(res_neg) : 60'(res_pos));
    assign idx_val   = cnt_reg + SCW'(1);
    assign end_val   = (32'(idx_val) >= 32'(steps_reg)) || (&idx_val);
    assign y_val     = (!integ_reg[47] && integ_reg != 48'sd0) ? res_neg : res_pos;
    assign k_val     = y_val >>> F;

    // square root digit step
    logic [SQ+1:0]         sq_r2;
    logic [SQ+1:0]         sq_trial;
    logic                  sq_ge;

    assign sq_r2    = {sq_rem_reg[SQ-1:0], sq_val_reg[SQV-1:SQV-2]};
    assign sq_trial = {sq_root_reg, 2'b01};
    assign sq_ge    = sq_r2 >= sq_trial;

    // final scaling of 2^frac by 2^k
    logic signed [YW:0]    s_val;
    logic [32:0]           v_val;

    assign s_val = S_BASE - {k_reg[YW-1], k_reg};

    always_comb
    begin
        priority if (s_val >= (YW + 1)'(31))
            v_val = '0;
        else if (s_val[YW])
            v_val = {sum_reg, 1'b0};
        else
            v_val = 33'(sum_reg >> s_val[4:0]);
    end

    // result hand-over into the output register
    logic                  fin_load;

    assign fin_load = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            a_reg     <= '0;
            b_reg     <= '0;
            r0_reg    <= '0;
            vol_reg   <= '0;
            dt_reg    <= '0;
            sqdt_reg  <= '0;
            steps_reg <= STEPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODEL_MODE:     mode_reg  <= cfg_data[0];
                REG_MEAN_REVERSION: a_reg     <= cfg_data[30:0];
                REG_LONG_RUN_MEAN:  b_reg     <= cfg_data;
                REG_START_RATE:     r0_reg    <= cfg_data;
                REG_VOLATILITY:     vol_reg   <= cfg_data[30:0];
                REG_STEP_TIME:      dt_reg    <= cfg_data[24:0];
                REG_SQRT_STEP_TIME: sqdt_reg  <= cfg_data[24:0];
                REG_STEPS_PER_PATH: steps_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_INTG;
            phase_reg     <= 1'b0;
            cur_rate_reg  <= '0;
            cnt_reg       <= '0;
            integ_reg     <= '0;
            it_reg        <= '0;
            div_i_reg     <= 4'd1;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        z_reg     <= normal_sample;
                        rate_reg  <= (cnt_reg == '0) ? r0_reg : cur_rate_reg;
                        op_reg    <= OP_INTG;
                        phase_reg <= 1'b0;
                        state_reg <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    acc_reg   <= acc_next;
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                        state_reg <= ST_POST;
                end

                ST_POST:
                begin
                    unique case (op_reg)
                        OP_INTG:
                        begin
                            // left Riemann sum, saturated to 48 bits
                            if (integ_sum > 58'sh7FFF_FFFF_FFFF)
                                integ_reg <= 48'sh7FFF_FFFF_FFFF;
                            else if (integ_sum < -58'sh8000_0000_0000)
                                integ_reg <= 48'sh8000_0000_0000;
                            else
                                integ_reg <= integ_sum[47:0];
                            op_reg    <= OP_T1;
                            state_reg <= ST_MUL;
                        end
                        OP_T1:
                        begin
                            t1_reg    <= res;
                            op_reg    <= OP_DRIFT;
                            state_reg <= ST_MUL;
                        end
                        OP_DRIFT:
                        begin
                            drift_reg <= d_val[32] ? res_neg : res_pos;
                            if (mode_reg && !rate_reg[31] && rate_reg != '0)
                            begin
                                sq_val_reg  <= SQV'({rate_reg[30:0], {F{1'b0}}});
                                sq_rem_reg  <= '0;
                                sq_root_reg <= '0;
                                it_reg      <= '0;
                                state_reg   <= ST_SQRT;
                            end
                            else
                            begin
                                vg_reg    <= mode_reg ? '0 : AW'(vol_reg);
                                op_reg    <= OP_T2;
                                state_reg <= ST_MUL;
                            end
                        end
                        OP_VG:
                        begin
                            vg_reg    <= res;
                            op_reg    <= OP_T2;
                            state_reg <= ST_MUL;
                        end
                        OP_T2:
                        begin
                            t2_reg    <= res;
                            op_reg    <= OP_DIFF;
                            state_reg <= ST_MUL;
                        end
                        OP_DIFF:
                        begin
                            if (nr_sum > 60'sh7FFF_FFFF)
                                nr_reg <= 32'sh7FFF_FFFF;
                            else if (nr_sum < -60'sh8000_0000)
                                nr_reg <= 32'sh8000_0000;
                            else
                                nr_reg <= nr_sum[31:0];
                            cur_rate_reg <= (nr_sum > 60'sh7FFF_FFFF) ? 32'sh7FFF_FFFF
                                          : (nr_sum < -60'sh8000_0000) ? 32'sh8000_0000
                                          : nr_sum[31:0];
                            idx_reg <= idx_val;
                            end_reg <= end_val;
                            cnt_reg <= end_val ? '0 : idx_val;
                            if (end_val)
                            begin
                                op_reg    <= OP_Y;
                                state_reg <= ST_MUL;
                            end
                            else
                            begin
                                disc_reg  <= '0;
                                state_reg <= ST_FIN;
                            end
                        end
                        OP_Y:
                        begin
                            // y = -I*log2(e); integer part k, fraction f
                            if (k_val >= K_LIMIT)
                            begin
                                disc_reg  <= 32'hFFFF_FFFF;
                                state_reg <= ST_FIN;
                            end
                            else
                            begin
                                k_reg     <= k_val;
                                f_reg     <= y_val[F-1:0];
                                op_reg    <= OP_T;
                                state_reg <= ST_MUL;
                            end
                        end
                        OP_T:
                        begin
                            t_reg     <= res[TERM_W-1:0];
                            term_reg  <= TERM_W'(Q30_ONE);
                            sum_reg   <= Q30_ONE;
                            div_i_reg <= 4'd1;
                            op_reg    <= OP_TERM;
                            state_reg <= ST_MUL;
                        end
                        OP_TERM:
                        begin
                            if (div_i_reg == 4'd1)
                            begin
                                term_reg  <= res[TERM_W-1:0];
                                sum_reg   <= sum_reg + 32'(res[TERM_W-1:0]);
                                div_i_reg <= 4'd2;
                            end
                            else
                            begin
                                div_x_reg <= res[TERM_W-1:0];
                                op_reg    <= OP_DIV;
                            end
                            state_reg <= ST_MUL;
                        end
                        OP_DIV:
                        begin
                            // term / i by reciprocal product
                            term_reg <= res[TERM_W-1:0];
                            sum_reg  <= sum_reg + 32'(res[TERM_W-1:0]);
                            if (div_i_reg == 4'(EXP_TERMS))
                                state_reg <= ST_EXPFIN;
                            else
                            begin
                                div_i_reg <= div_i_reg + 4'd1;
                                op_reg    <= OP_TERM;
                                state_reg <= ST_MUL;
                            end
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end

                ST_SQRT:
                begin
                    sq_val_reg <= {sq_val_reg[SQV-3:0], 2'b00};
                    if (sq_ge)
                    begin
                        sq_rem_reg  <= sq_r2 - sq_trial;
                        sq_root_reg <= {sq_root_reg[SQ-2:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg  <= sq_r2;
                        sq_root_reg <= {sq_root_reg[SQ-2:0], 1'b0};
                    end
                    it_reg <= it_reg + ITW'(1);
                    if (it_reg == ITW'(SQ - 1))
                    begin
                        op_reg    <= OP_VG;
                        phase_reg <= 1'b0;
                        state_reg <= ST_MUL;
                    end
                end

                ST_EXPFIN:
                begin
                    disc_reg  <= v_val[32] ? 32'hFFFF_FFFF : v_val[31:0];
                    state_reg <= ST_FIN;
                end

                ST_FIN:
                begin
                    // hand over once the output register is free
                    if (fin_load)
                    begin
                        out_rate_reg  <= nr_reg;
                        out_idx_reg   <= 16'(idx_reg);
                        out_end_reg   <= end_reg;
                        out_disc_reg  <= disc_reg;
                        if (end_reg)
                            integ_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign new_rate        = out_rate_reg;
    assign step_index      = out_idx_reg;
    assign path_end        = out_end_reg;
    assign discount_factor = out_disc_reg;

    // ---------------- assertions ----------------
    a_disc_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !path_end |-> discount_factor == 32'd0)
        else $error("discount factor nonzero off path end");

    a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQRT |-> it_reg < ITW'(SQ) && !rate_reg[31])
        else $error("square root out of range");

    a_div_index: assert property (@(posedge clk) disable iff (!rst_n)
        op_reg == OP_DIV |-> div_i_reg >= 4'd2 && div_i_reg <= 4'(EXP_TERMS))
        else $error("series divisor out of range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_FIN)
        else $error("result shown without finishing a step");

endmodule
